[hw/rtl/swsc_pkg.sv]
package swsc_pkg;

  localparam int SAMPLE_W       = 20;
  localparam int RANGE_W        = 20;
  localparam int WL_CFG_W       = 5;
  localparam int TOL_W          = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int RING_DEPTH_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_TOLERANCE = 1'd1;

  localparam logic [WL_CFG_W-1:0] WL_RESET  = 5'd4;
  localparam logic [TOL_W-1:0]    TOL_RESET = 16'd10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       new_series;
  } in_item_t;

  typedef struct packed {
    logic                       stable;
    logic signed [SAMPLE_W-1:0] window_mean;
    logic [RANGE_W-1:0]         window_range;
  } out_item_t;

endpackage

[hw/rtl/sliding_window_stability_check.sv]
// Sliding-window stability check for probe height samples.
// Input channel (in_valid/in_stall/in_data): one signed sample per transaction,
// with a new_series flag that restarts the gathered count before storing it.
// Result channel (out_valid/out_stall/out_data): exactly one transaction per
// input: stable flag, window mean (truncated toward zero) and window range.
// Configuration (cfg_we/cfg_index/cfg_data): index 0 sets the window length,
// index 1 the range tolerance; write only while the block is idle.
// Steps: when the window is not yet full, an accepted sample goes straight to
// ST_OUT. Otherwise ST_SCAN walks the ring memory one entry a cycle through its
// single read port, ST_RANGE forms range and compare, a stable window adds a
// bit-serial restoring divide in ST_DIV, and ST_OUT hands the result to the
// output register.
// Flow: in_stall stays high from accept until the result moves into the
// output register, so a new transaction is taken only after the result of the
// last one has moved into the output register.
// A stalled receiver holds the result in the output register while the next
// transaction is processed; that one waits only if its result is ready first.
// Reset (synchronous, rst_n low) clears write position, gathered count and
// restores window length 4 and tolerance 10; ring contents are not cleared.
module sliding_window_stability_check
  import swsc_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + PTR_W;
  localparam int DCNT_W = $clog2(SUM_W);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_RANGE = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [PTR_W-1:0]           wr_pos_r, wr_pos_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [WL_CFG_W-1:0]        cfg_wl_r, cfg_wl_nxt;
  logic [TOL_W-1:0]           tol_r, tol_nxt;
  logic [CNT_W-1:0]           wl_r, wl_nxt;
  logic [PTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]           issue_left_r, issue_left_nxt;
  logic                       data_vld_r, data_vld_nxt;
  logic                       first_r, first_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic                       neg_r, neg_nxt;
  logic [SUM_W-1:0]           dq_r, dq_nxt;
  logic [CNT_W-1:0]           rem_r, rem_nxt;
  logic [DCNT_W-1:0]          div_cnt_r, div_cnt_nxt;
  out_item_t                  res_r, res_nxt;
  out_item_t                  out_r, out_nxt;
  logic                       out_vld_r, out_vld_nxt;

  logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;

  logic                       accept;
  logic [31:0]                wl_full;
  logic [CNT_W-1:0]           wl_clamp;
  logic [PTR_W-1:0]           wr_pos_inc;
  logic [CNT_W-1:0]           cnt_upd;
  logic [31:0]                start_full;
  logic signed [SAMPLE_W:0]   diff;
  logic [CNT_W:0]             rem_sh;
  logic                       q_bit;
  logic [SUM_W-1:0]           dq_step;
  logic [SUM_W-1:0]           mean_full;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_comb begin
    if (cfg_wl_r == '0) begin
      wl_full = 32'd1;
    end else if (32'(cfg_wl_r) > 32'(RING_DEPTH)) begin
      wl_full = 32'(RING_DEPTH);
    end else begin
      wl_full = 32'(cfg_wl_r);
    end
    wl_clamp = wl_full[CNT_W-1:0];

    wr_pos_inc = (wr_pos_r == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_pos_r + 1'b1;

    if (in_data.new_series) begin
      cnt_upd = CNT_W'(1);
    end else if (cnt_r < CNT_W'(RING_DEPTH)) begin
      cnt_upd = cnt_r + 1'b1;
    end else begin
      cnt_upd = cnt_r;
    end

    // oldest entry of the window, counted back from the next write slot
    start_full = 32'(wr_pos_inc) + 32'(RING_DEPTH) - 32'(wl_clamp);
    if (start_full >= 32'(RING_DEPTH)) begin
      start_full = start_full - 32'(RING_DEPTH);
    end

    diff = {max_r[SAMPLE_W-1], max_r} - {min_r[SAMPLE_W-1], min_r};

    rem_sh  = {rem_r, dq_r[SUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, wl_r});
    dq_step = {dq_r[SUM_W-2:0], q_bit};
    mean_full = neg_r ? (~dq_step + 1'b1) : dq_step;
  end

  always_comb begin
    state_nxt      = state_r;
    wr_pos_nxt     = wr_pos_r;
    cnt_nxt        = cnt_r;
    cfg_wl_nxt     = cfg_wl_r;
    tol_nxt        = tol_r;
    wl_nxt         = wl_r;
    rd_ptr_nxt     = rd_ptr_r;
    issue_left_nxt = issue_left_r;
    data_vld_nxt   = 1'b0;
    first_nxt      = first_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    sum_nxt        = sum_r;
    neg_nxt        = neg_r;
    dq_nxt         = dq_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    // drop the output transaction once the receiver has taken it
    out_vld_nxt    = out_vld_r && out_stall;

    if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH:   cfg_wl_nxt = cfg_data[WL_CFG_W-1:0];
        CFG_RANGE_TOLERANCE: tol_nxt    = cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          wr_pos_nxt     = wr_pos_inc;
          cnt_nxt        = cnt_upd;
          wl_nxt         = wl_clamp;
          rd_ptr_nxt     = start_full[PTR_W-1:0];
          issue_left_nxt = wl_clamp;
          first_nxt      = 1'b1;
          if (cnt_upd < wl_clamp) begin
            res_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, consume the data of the previous one
        if (issue_left_r != '0) begin
          issue_left_nxt = issue_left_r - 1'b1;
          rd_ptr_nxt     = (rd_ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
          data_vld_nxt   = 1'b1;
        end
        if (data_vld_r) begin
          first_nxt = 1'b0;
          if (first_r) begin
            min_nxt = rd_data_r;
            max_nxt = rd_data_r;
            sum_nxt = SUM_W'(rd_data_r);
          end else begin
            if (rd_data_r < min_r) min_nxt = rd_data_r;
            if (rd_data_r > max_r) max_nxt = rd_data_r;
            sum_nxt = sum_r + SUM_W'(rd_data_r);
          end
          if (issue_left_r == '0) begin
            state_nxt = ST_RANGE;
          end
        end
      end
      ST_RANGE: begin
        res_nxt.window_range = diff[RANGE_W-1:0];
        res_nxt.window_mean  = '0;
        if ($unsigned(diff) <= (SAMPLE_W+1)'(tol_r)) begin
          res_nxt.stable = 1'b1;
          neg_nxt        = sum_r[SUM_W-1];
          dq_nxt         = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
          rem_nxt        = '0;
          div_cnt_nxt    = '0;
          state_nxt      = ST_DIV;
        end else begin
          res_nxt.stable = 1'b0;
          state_nxt      = ST_OUT;
        end
      end
      ST_DIV: begin
        rem_nxt     = q_bit ? CNT_W'(rem_sh - {1'b0, wl_r}) : rem_sh[CNT_W-1:0];
        dq_nxt      = dq_step;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DCNT_W'(SUM_W - 1)) begin
          res_nxt.window_mean = mean_full[SAMPLE_W-1:0];
          state_nxt           = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free or being emptied
        if (!out_vld_r || !out_stall) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wr_pos_r   <= '0;
      cnt_r      <= '0;
      cfg_wl_r   <= WL_RESET;
      tol_r      <= TOL_RESET;
      data_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wr_pos_r   <= wr_pos_nxt;
      cnt_r      <= cnt_nxt;
      cfg_wl_r   <= cfg_wl_nxt;
      tol_r      <= tol_nxt;
      data_vld_r <= data_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wl_r         <= wl_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    issue_left_r <= issue_left_nxt;
    first_r      <= first_nxt;
    min_r        <= min_nxt;
    max_r        <= max_nxt;
    sum_r        <= sum_nxt;
    neg_r        <= neg_nxt;
    dq_r         <= dq_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring_mem[wr_pos_r] <= in_data.sample;
    end
    rd_data_r <= ring_mem[rd_ptr_r];
  end

endmodule

[test/tb_sliding_window_stability_check.sv]
module tb_sliding_window_stability_check;
  import swsc_pkg::*;

  localparam int NUM_PHASES = 7;
  localparam int PHASE_ITEMS = 100;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Per-phase register settings and handshake pressure
  int unsigned phase_len[NUM_PHASES] = '{16, 1, 0, 31, 8, 17, 3};
  int unsigned phase_tol[NUM_PHASES] = '{65535, 0, 5, 1000, 200, 50, 20};
  int phase_send_idle[NUM_PHASES] = '{0, 68, 0, 30, 68, 0, 30};
  int phase_recv_stall[NUM_PHASES] = '{0, 0, 68, 30, 0, 68, 30};

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int in_presented = 0;
  int in_accepted = 0;
  int results_checked = 0;
  int stable_seen = 0;
  int fail_count = 0;

  // Predictor state
  logic signed [SAMPLE_W-1:0] height_hist[RING_DEPTH_DEF];
  int wr_pos;
  int fill_count;
  logic [WL_CFG_W-1:0] win_len;
  logic [TOL_W-1:0] tol;

  sliding_window_stability_check u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("sliding_window_stability_check test failed");
    $finish;
  end

  // Store the sample, then evaluate the window that ends with it
  function automatic out_item_t predict_window(in_item_t item);
    out_item_t res;
    int eff_len, oldest, k, v, lo, hi, spread;
    longint total;
    res = '0;
    if (item.new_series) fill_count = 0;
    height_hist[wr_pos] = item.sample;
    wr_pos = (wr_pos + 1) % RING_DEPTH_DEF;
    if (fill_count < RING_DEPTH_DEF) fill_count++;
    eff_len = (win_len == 0) ? 1 : int'(win_len);
    if (eff_len > RING_DEPTH_DEF) eff_len = RING_DEPTH_DEF;
    if (fill_count >= eff_len) begin
      oldest = (wr_pos + RING_DEPTH_DEF - eff_len) % RING_DEPTH_DEF;
      lo = height_hist[oldest];
      hi = lo;
      total = 0;
      for (k = 0; k < eff_len; k++) begin
        v = height_hist[(oldest + k) % RING_DEPTH_DEF];
        if (v < lo) lo = v;
        if (v > hi) hi = v;
        total += v;
      end
      spread = hi - lo;
      res.window_range = RANGE_W'(spread);
      if (spread <= int'(tol)) begin
        res.stable = 1'b1;
        res.window_mean = SAMPLE_W'(total / eff_len);
      end
    end
    return res;
  endfunction

  function automatic in_item_t probe_item(int height, bit restart);
    in_item_t item;
    item.sample = SAMPLE_W'(height);
    item.new_series = restart;
    return item;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Driver: hold an unaccepted transaction, otherwise advance or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_accepted != in_presented) begin
      // hold
    end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data <= pending_items.pop_front();
      in_presented++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: check result transactions, predict on input transactions
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: stable=%0b mean=%0d range=%0d",
                                 out_data.stable, out_data.window_mean,
                                 out_data.window_range));
        end else begin
          want = expected_results.pop_front();
          if (out_data.stable !== want.stable || out_data.window_mean !== want.window_mean
              || out_data.window_range !== want.window_range) begin
            note_failure($sformatf(
                "mismatch on result %0d: expected stable=%0b mean=%0d range=%0d, got stable=%0b mean=%0d range=%0d",
                results_checked, want.stable, want.window_mean, want.window_range,
                out_data.stable, out_data.window_mean, out_data.window_range));
          end
          results_checked++;
          if (out_data.stable === 1'b1) stable_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_window(in_data));
        in_accepted++;
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_presented != in_accepted
           || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic apply_settings(int unsigned length, int unsigned tolerance);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_WINDOW_LENGTH;
    cfg_data = CFG_DATA_W'(length);
    win_len = WL_CFG_W'(length);
    @(negedge clk);
    cfg_index = CFG_RANGE_TOLERANCE;
    cfg_data = CFG_DATA_W'(tolerance);
    tol = TOL_W'(tolerance);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int p, n, roll, spread, center;
    bit restart;
    for (n = 0; n < RING_DEPTH_DEF; n++) height_hist[n] = '0;
    wr_pos = 0;
    fill_count = 0;
    win_len = WL_CFG_W'(WL_RESET);
    tol = TOL_W'(TOL_RESET);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings (window 4, tolerance 10)
    pending_items.push_back(probe_item(100, 1));
    pending_items.push_back(probe_item(105, 0));
    pending_items.push_back(probe_item(110, 0));
    pending_items.push_back(probe_item(104, 0));   // range equals tolerance
    pending_items.push_back(probe_item(111, 0));
    pending_items.push_back(probe_item(115, 0));   // one over tolerance
    pending_items.push_back(probe_item(-100, 0));
    pending_items.push_back(probe_item(-101, 0));
    pending_items.push_back(probe_item(-102, 0));
    pending_items.push_back(probe_item(-102, 0));  // negative mean truncates up
    pending_items.push_back(probe_item(-3, 1));
    pending_items.push_back(probe_item(-2, 0));
    pending_items.push_back(probe_item(-2, 0));
    pending_items.push_back(probe_item(-2, 0));
    pending_items.push_back(probe_item(524287, 1));
    pending_items.push_back(probe_item(524287, 0));
    pending_items.push_back(probe_item(524287, 0));
    pending_items.push_back(probe_item(524287, 0));
    pending_items.push_back(probe_item(-524288, 0));
    pending_items.push_back(probe_item(-524288, 0));
    pending_items.push_back(probe_item(-524288, 0));
    pending_items.push_back(probe_item(-524288, 0));
    pending_items.push_back(probe_item(0, 0));
    pending_items.push_back(probe_item(524287, 0)); // widest range
    pending_items.push_back(probe_item(0, 1));
    wait_drained();

    for (p = 0; p < NUM_PHASES; p++) begin
      apply_settings(phase_len[p], phase_tol[p]);
      send_idle_pct = phase_send_idle[p];
      recv_stall_pct = phase_recv_stall[p];
      // Mostly clustered heights around a drifting center, so windows settle
      spread = int'(phase_tol[p]) + int'(phase_tol[p]) / 8 + 1;
      center = int'($urandom_range(960000)) - 480000;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        restart = ($urandom_range(24) == 0);
        if (restart || $urandom_range(49) == 0)
          center = int'($urandom_range(960000)) - 480000;
        if (roll < 8)
          pending_items.push_back(probe_item(int'($urandom), restart));
        else if (roll < 11)
          pending_items.push_back(probe_item($urandom_range(1) ? 524287 : -524288, restart));
        else
          pending_items.push_back(probe_item(center + int'($urandom_range(spread)) - spread / 2,
                                             restart));
      end
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (60) @(posedge clk);

    $display("checked %0d results from %0d samples over %0d register settings",
             results_checked, in_accepted, NUM_PHASES + 1);
    $display("%0d stable windows seen, %0d failures", stable_seen, fail_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("sliding_window_stability_check test passed");
    end else begin
      $display("sliding_window_stability_check test failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/swsc_pkg.sv
hw/rtl/sliding_window_stability_check.sv
test/tb_sliding_window_stability_check.sv
